// ===== rtl/pbm_pkg.sv =====
// shared request/response types and codes for the page buffer lru pin manager
package pbm_pkg;

   typedef enum logic [1:0] {
      MODE_FETCH = 2'd0,
      MODE_NEW   = 2'd1,
      MODE_UNPIN = 2'd2,
      MODE_FLUSH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_PLACED   = 2'd1,
      ST_NO_FRAME = 2'd2,
      ST_ABSENT   = 2'd3
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] page_number;
      logic        set_dirty;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  frame_index;
      logic        load_request;
      logic        writeback_valid;
      logic [31:0] writeback_page;
      logic [3:0]  writeback_frame;
   } rsp_type;

endpackage

// ===== rtl/pbm_scan.sv =====
// frame scan unit: one shared tag compare and rank compare stepped over all frames
module pbm_scan #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 32,
   parameter int PIN_BITS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        scan_start,
   input  logic [PAGE_BITS-1:0]        page,
   input  logic                        entry_valid,
   input  logic [PAGE_BITS-1:0]        entry_tag,
   input  logic [PIN_BITS-1:0]         entry_pin,
   input  logic                        entry_dirty,
   input  logic [$clog2(FRAMES)-1:0]   entry_rank,
   output logic [$clog2(FRAMES)-1:0]   idx,
   output logic                        done,
   output logic                        hit_found,
   output logic [$clog2(FRAMES)-1:0]   hit_idx,
   output logic [$clog2(FRAMES)-1:0]   hit_rank,
   output logic [PIN_BITS-1:0]         hit_pin,
   output logic                        hit_dirty,
   output logic [PAGE_BITS-1:0]        hit_tag,
   output logic                        inv_found,
   output logic [$clog2(FRAMES)-1:0]   inv_idx,
   output logic                        vic_found,
   output logic [$clog2(FRAMES)-1:0]   vic_idx,
   output logic [$clog2(FRAMES)-1:0]   vic_rank,
   output logic                        vic_dirty,
   output logic [PAGE_BITS-1:0]        vic_tag,
   output logic [$clog2(FRAMES):0]     count
);
   import pbm_pkg::*;

   localparam int FIDX = $clog2(FRAMES);

   logic              active_ff, done_ff;
   logic [FIDX-1:0]   idx_ff;
   logic              hit_found_ff, inv_found_ff, vic_found_ff;
   logic [FIDX-1:0]   hit_idx_ff, hit_rank_ff, inv_idx_ff, vic_idx_ff, vic_rank_ff;
   logic [PIN_BITS-1:0] hit_pin_ff;
   logic              hit_dirty_ff, vic_dirty_ff;
   logic [PAGE_BITS-1:0] hit_tag_ff, vic_tag_ff;
   logic [FIDX:0]     count_ff;
   logic              is_hit, is_inv, is_vic;

   assign is_hit = entry_valid && (entry_tag == page) && !hit_found_ff;
   assign is_inv = !entry_valid && !inv_found_ff;
   // strict compare keeps the lowest index among equal ranks
   assign is_vic = entry_valid && (entry_pin == '0)
                   && (!vic_found_ff || (entry_rank < vic_rank_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         idx_ff       <= '0;
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         done_ff <= 1'b0;
         if (scan_start) begin
            active_ff    <= 1'b1;
            idx_ff       <= '0;
            hit_found_ff <= 1'b0;
            inv_found_ff <= 1'b0;
            vic_found_ff <= 1'b0;
            count_ff     <= '0;
         end else if (active_ff) begin
            if (entry_valid) count_ff <= count_ff + 1'b1;
            if (is_hit) hit_found_ff <= 1'b1;
            if (is_inv) inv_found_ff <= 1'b1;
            if (is_vic) vic_found_ff <= 1'b1;
            if (idx_ff == FIDX'(FRAMES - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   // captured entry fields, no reset needed
   always_ff @(posedge clock) begin
      if (active_ff && !scan_start) begin
         if (is_hit) begin
            hit_idx_ff   <= idx_ff;
            hit_rank_ff  <= entry_rank;
            hit_pin_ff   <= entry_pin;
            hit_dirty_ff <= entry_dirty;
            hit_tag_ff   <= entry_tag;
         end
         if (is_inv) inv_idx_ff <= idx_ff;
         if (is_vic) begin
            vic_idx_ff   <= idx_ff;
            vic_rank_ff  <= entry_rank;
            vic_dirty_ff <= entry_dirty;
            vic_tag_ff   <= entry_tag;
         end
      end
   end

   assign idx       = idx_ff;
   assign done      = done_ff;
   assign hit_found = hit_found_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_rank  = hit_rank_ff;
   assign hit_pin   = hit_pin_ff;
   assign hit_dirty = hit_dirty_ff;
   assign hit_tag   = hit_tag_ff;
   assign inv_found = inv_found_ff;
   assign inv_idx   = inv_idx_ff;
   assign vic_found = vic_found_ff;
   assign vic_idx   = vic_idx_ff;
   assign vic_rank  = vic_rank_ff;
   assign vic_dirty = vic_dirty_ff;
   assign vic_tag   = vic_tag_ff;
   assign count     = count_ff;

endmodule

// ===== rtl/page_buffer_lru_pin_manager_top.sv =====
// top level: frame state, request sequencer and response register
//
//   channel   ports                          transfer when
//   request   start, busy, req_payload       start && !busy
//   response  rsp_strobe, rsp_payload        rsp_strobe (one cycle)
//
// each request is latched, then the scan is launched and steps through the
// frame table with the shared compare unit, and the update is applied at its end.
// the response strobes in the cycle after the update, when busy is already low.
// reset clears valid, pin, dirty and rank state at once; tags are not cleared.
// the receiver cannot stall; start is ignored while busy.
module page_buffer_lru_pin_manager_top #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 32,
   parameter int PIN_BITS  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pbm_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output pbm_pkg::rsp_type rsp_payload
);
   import pbm_pkg::*;

   localparam int FIDX = $clog2(FRAMES);

   typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_SCAN} state_type;

   state_type            state_ff;
   req_type              req_ff;
   rsp_type              rsp_ff;
   logic                 strobe_ff;

   logic [PAGE_BITS-1:0] tag_ff   [FRAMES];
   logic [FRAMES-1:0]    valid_ff;
   logic [PIN_BITS-1:0]  pin_ff   [FRAMES];
   logic [FRAMES-1:0]    dirty_ff;
   logic [FIDX-1:0]      rank_ff  [FRAMES];

   logic [63:0]          page_wide;
   logic [PAGE_BITS-1:0] page;
   logic [FIDX-1:0]      idx;
   logic                 done;
   logic                 hit_found, inv_found, vic_found, hit_dirty, vic_dirty;
   logic [FIDX-1:0]      hit_idx, hit_rank, inv_idx, vic_idx, vic_rank;
   logic [PIN_BITS-1:0]  hit_pin;
   logic [PAGE_BITS-1:0] hit_tag, vic_tag;
   logic [FIDX:0]        count;

   // action decode
   logic [FIDX-1:0]      act_f, act_r, act_rank;
   logic                 act_shift, we_rank, we_pin, we_dirty, we_fill;
   logic [PIN_BITS-1:0]  act_pin;
   logic                 act_dirty;
   rsp_type              rsp_in;
   logic [63:0]          wb_wide, fi_wide;

   assign page_wide = 64'(req_ff.page_number);
   assign page      = page_wide[PAGE_BITS-1:0];

   pbm_scan #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .PIN_BITS(PIN_BITS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .scan_start  (state_ff == S_LAUNCH),
      .page        (page),
      .entry_valid (valid_ff[idx]),
      .entry_tag   (tag_ff[idx]),
      .entry_pin   (pin_ff[idx]),
      .entry_dirty (dirty_ff[idx]),
      .entry_rank  (rank_ff[idx]),
      .idx         (idx),
      .done        (done),
      .hit_found   (hit_found),
      .hit_idx     (hit_idx),
      .hit_rank    (hit_rank),
      .hit_pin     (hit_pin),
      .hit_dirty   (hit_dirty),
      .hit_tag     (hit_tag),
      .inv_found   (inv_found),
      .inv_idx     (inv_idx),
      .vic_found   (vic_found),
      .vic_idx     (vic_idx),
      .vic_rank    (vic_rank),
      .vic_dirty   (vic_dirty),
      .vic_tag     (vic_tag),
      .count       (count)
   );

   always_comb begin
      act_f     = hit_idx;
      act_r     = hit_rank;
      act_rank  = FIDX'(count - 1'b1);
      act_shift = 1'b0;
      we_rank   = 1'b0;
      we_pin    = 1'b0;
      we_dirty  = 1'b0;
      we_fill   = 1'b0;
      act_pin   = hit_pin;
      act_dirty = hit_dirty;
      wb_wide   = 64'(hit_tag);
      rsp_in    = '0;
      rsp_in.status = ST_DONE;
      case (req_ff.mode)
         MODE_FETCH, MODE_NEW: begin
            if (hit_found) begin
               act_shift = 1'b1;
               we_rank   = 1'b1;
               we_pin    = 1'b1;
               act_pin   = (hit_pin == '1) ? hit_pin : hit_pin + 1'b1;
            end else if (inv_found || vic_found) begin
               we_rank   = 1'b1;
               we_pin    = 1'b1;
               we_dirty  = 1'b1;
               we_fill   = 1'b1;
               act_pin   = PIN_BITS'(1);
               act_dirty = 1'b0;
               rsp_in.status       = ST_PLACED;
               rsp_in.load_request = (req_ff.mode == MODE_FETCH);
               if (inv_found) begin
                  act_f    = inv_idx;
                  act_rank = FIDX'(count);
               end else begin
                  act_f     = vic_idx;
                  act_r     = vic_rank;
                  act_shift = 1'b1;
                  wb_wide   = 64'(vic_tag);
                  rsp_in.writeback_valid = vic_dirty;
               end
            end else begin
               rsp_in.status = ST_NO_FRAME;
            end
         end
         MODE_UNPIN: begin
            if (hit_found) begin
               we_pin    = 1'b1;
               we_dirty  = 1'b1;
               act_pin   = (hit_pin == '0) ? hit_pin : hit_pin - 1'b1;
               act_dirty = hit_dirty | req_ff.set_dirty;
            end else begin
               rsp_in.status = ST_ABSENT;
            end
         end
         MODE_FLUSH: begin
            if (hit_found) begin
               we_dirty  = 1'b1;
               act_dirty = 1'b0;
               rsp_in.writeback_valid = hit_dirty;
            end else begin
               rsp_in.status = ST_ABSENT;
            end
         end
         default: rsp_in.status = ST_ABSENT;
      endcase
      fi_wide = 64'(act_f);
      if (rsp_in.status == ST_DONE || rsp_in.status == ST_PLACED)
         rsp_in.frame_index = fi_wide[3:0];
      if (rsp_in.writeback_valid) begin
         rsp_in.writeback_page  = wb_wide[31:0];
         rsp_in.writeback_frame = fi_wide[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_payload;
                  state_ff <= S_LAUNCH;
               end
            end
            S_LAUNCH: state_ff <= S_SCAN;
            S_SCAN: begin
               if (done) begin
                  rsp_ff    <= rsp_in;
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // frame table update, all ranks adjusted in parallel
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            pin_ff[i]  <= '0;
            rank_ff[i] <= '0;
         end
      end else if (state_ff == S_SCAN && done) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (FIDX'(i) != act_f) begin
               if (act_shift && valid_ff[i] && rank_ff[i] > act_r)
                  rank_ff[i] <= rank_ff[i] - 1'b1;
            end else begin
               if (we_rank)  rank_ff[i]  <= act_rank;
               if (we_pin)   pin_ff[i]   <= act_pin;
               if (we_dirty) dirty_ff[i] <= act_dirty;
               if (we_fill)  valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && done && we_fill) tag_ff[act_f] <= page;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not raise busy");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("response without a request in flight");
   a_load_only_placed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != ST_PLACED |-> !rsp_payload.load_request)
      else $error("load request outside placement");

endmodule

// ===== sim/tb_page_buffer_lru_pin_manager_top.sv =====
// testbench for the page buffer lru pin manager: random and directed requests checked by a predictor
module tb_page_buffer_lru_pin_manager_top;
   import pbm_pkg::*;

   localparam int NFRAMES = 16;
   localparam int PIN_MAX = 255;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      failures = 0;

   page_buffer_lru_pin_manager_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // frame table mirror with lru ranks; one answer per request
   class frame_scoreboard;
      logic [31:0] tag [NFRAMES];
      bit          valid [NFRAMES];
      int          pins [NFRAMES];
      bit          dirty [NFRAMES];
      int          rank [NFRAMES];
      rsp_type     pending [$];

      function void clear_frames();
         for (int i = 0; i < NFRAMES; i++) begin
            tag[i] = '0; valid[i] = 0; pins[i] = 0; dirty[i] = 0; rank[i] = 0;
         end
      endfunction

      function int resident_count();
         int n;
         n = 0;
         foreach (valid[i]) n += valid[i];
         return n;
      endfunction

      function int lookup(logic [31:0] p);
         for (int i = 0; i < NFRAMES; i++) if (valid[i] && tag[i] == p) return i;
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type o;
         int f, v, n, old;
         o = '0;
         f = lookup(r.page_number);
         if (r.mode == MODE_FETCH || r.mode == MODE_NEW) begin
            if (f >= 0) begin
               n = resident_count();
               old = rank[f];
               for (int i = 0; i < NFRAMES; i++)
                  if (i != f && valid[i] && rank[i] > old) rank[i]--;
               rank[f] = n - 1;
               if (pins[f] < PIN_MAX) pins[f]++;
               o.status = ST_DONE; o.frame_index = f;
            end else begin
               v = -1;
               for (int i = 0; i < NFRAMES; i++) if (!valid[i]) begin v = i; break; end
               if (v < 0) begin
                  for (int i = 0; i < NFRAMES; i++)
                     if (pins[i] == 0 && (v < 0 || rank[i] < rank[v])) v = i;
                  if (v >= 0) begin
                     if (dirty[v]) begin
                        o.writeback_valid = 1; o.writeback_page = tag[v];
                        o.writeback_frame = v;
                     end
                     old = rank[v];
                     valid[v] = 0;
                     for (int i = 0; i < NFRAMES; i++)
                        if (valid[i] && rank[i] > old) rank[i]--;
                  end
               end
               if (v < 0) o.status = ST_NO_FRAME;
               else begin
                  valid[v] = 1; tag[v] = r.page_number; pins[v] = 1; dirty[v] = 0;
                  rank[v] = resident_count() - 1;
                  o.status = ST_PLACED; o.frame_index = v;
                  o.load_request = (r.mode == MODE_FETCH);
               end
            end
         end else if (f < 0) begin
            o.status = ST_ABSENT;
         end else begin
            if (r.mode == MODE_UNPIN) begin
               if (r.set_dirty) dirty[f] = 1;
               if (pins[f] > 0) pins[f]--;
            end else if (dirty[f]) begin
               o.writeback_valid = 1; o.writeback_page = tag[f]; o.writeback_frame = f;
               dirty[f] = 0;
            end
            o.status = ST_DONE; o.frame_index = f;
         end
         pending = {pending, o};
      endfunction

      function int check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $time, a);
            return 1;
         end
         e = pending[0];
         pending.delete(0);
         if (a !== e) begin
            $display("%0t: response mismatch expected %p actual %p", $time, e, a);
            return 1;
         end
         return 0;
      endfunction
   endclass

   frame_scoreboard board = new();
   logic [31:0] page_pool [12];

   always @(posedge clock) begin
      if (!reset && rsp_strobe) failures += board.check_response(rsp_payload);
   end

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // start stays high after a transfer until a gap, a drain or the next request
   task automatic send_request(mode_type m, logic [31:0] p, logic d, bit gaps);
      req_type r;
      r.mode = m; r.page_number = p; r.set_dirty = d;
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer happens at this edge
      board.note_request(r);
      if (gaps) idle_gap();
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic mode_type pick_mode();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) return MODE_FETCH;
      if (k < 5) return MODE_NEW;
      if (k < 8) return MODE_UNPIN;
      return MODE_FLUSH;
   endfunction

   initial begin
      board.clear_frames();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, every mode, full pin, eviction
      send_request(MODE_UNPIN, 32'h0, 1'b1, 0);
      send_request(MODE_FLUSH, 32'hFFFF_FFFF, 1'b0, 0);
      send_request(MODE_FETCH, 32'hFFFF_FFFF, 1'b0, 0);
      send_request(MODE_NEW, 32'h0, 1'b0, 0);
      send_request(MODE_NEW, 32'hFFFF_FFFF, 1'b0, 0);
      send_request(MODE_UNPIN, 32'hFFFF_FFFF, 1'b1, 0);
      send_request(MODE_UNPIN, 32'hFFFF_FFFF, 1'b0, 0);
      send_request(MODE_UNPIN, 32'hFFFF_FFFF, 1'b0, 0);
      send_request(MODE_FLUSH, 32'hFFFF_FFFF, 1'b0, 0);
      send_request(MODE_FLUSH, 32'h0, 1'b0, 0);
      for (int i = 2; i < 16; i++) send_request(MODE_FETCH, 32'hA5A5_0000 + i, 1'b0, 0);
      send_request(MODE_FETCH, 32'h5A5A_5A5A, 1'b0, 0);
      send_request(MODE_UNPIN, 32'hA5A5_0003, 1'b1, 0);
      send_request(MODE_NEW, 32'h1234_5678, 1'b0, 0);
      drain();
      // pin counter saturation
      for (int i = 0; i < 260; i++) send_request(MODE_FETCH, 32'h0, 1'b0, 0);
      for (int i = 0; i < 262; i++) send_request(MODE_UNPIN, 32'h0, 1'b1, 0);
      // hold off until everything has answered
      drain();
      for (int i = 0; i < 12; i++) page_pool[i] = $urandom();
      for (int n = 0; n < 100; n++) begin
         logic [31:0] p;
         p = ($urandom_range(0, 7) == 0) ? $urandom() : page_pool[$urandom_range(0, 11)];
         if ($urandom_range(0, 19) == 0) page_pool[$urandom_range(0, 11)] = $urandom();
         send_request(pick_mode(), p, $urandom_range(0, 1), (n % 50) < 35);
      end
      drain();
      repeat (40) @(posedge clock);
      if (failures == 0 && board.pending.size() == 0)
         $display("[page_buffer_lru_pin_manager_top] OK");
      else
         $display("[page_buffer_lru_pin_manager_top] ERROR");
      $finish;
   end

   initial begin
      #200000;
      $display("[page_buffer_lru_pin_manager_top] ERROR");
      $finish;
   end
endmodule
